// ===== design/ple_pkg.sv =====
// ple_pkg: shared types and constants of the positional list engine
// holds list sizing, operation and status codes, cell select codes and the result struct
// no dependencies
package ple_pkg;

  // list sizing
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // fixed field widths of the channels
  localparam int OP_W    = 3;
  localparam int COLOR_W = 2;
  localparam int POS_W   = 5;
  localparam int FPOS_W  = 4;
  localparam int ECNT_W  = 5;

  // color code that never names an entry
  localparam logic [COLOR_W-1:0] COLOR_INVALID = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_DELETE  = 3'd2,
    OP_SEARCH  = 3'd3,
    OP_REVERSE = 3'd4,
    OP_DUMP    = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_COLOR = 3'd1,
    ST_BAD_POS   = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

  // where a cell takes its next value from
  typedef enum logic [2:0] {
    SEL_HOLD  = 3'd0,
    SEL_LEFT  = 3'd1,
    SEL_RIGHT = 3'd2,
    SEL_HEAD  = 3'd3,
    SEL_NEW   = 3'd4
  } sel_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_BUSY = 1'b1
  } fsm_e;

  typedef struct packed {
    status_e             status;
    logic [FPOS_W-1:0]   found_position;
    logic [COLOR_W-1:0]  entry_color;
    logic [ECNT_W-1:0]   entry_count;
    logic                last;
  } res_t;

endpackage

// ===== design/ple_cell.sv =====
// ple_cell: one slot of the list row, holds one color code
// takes its next value from itself, a neighbor, the head slot or the new color
// depends on ple_pkg
module ple_cell (
  input  logic                        clk_i,
  input  ple_pkg::sel_e               sel_i,
  input  logic [ple_pkg::COLOR_W-1:0] left_i,
  input  logic [ple_pkg::COLOR_W-1:0] right_i,
  input  logic [ple_pkg::COLOR_W-1:0] head_i,
  input  logic [ple_pkg::COLOR_W-1:0] new_i,
  output logic [ple_pkg::COLOR_W-1:0] value_o
);

  logic [ple_pkg::COLOR_W-1:0] value_q, value_d;

  // next value select
  always_comb begin
    case (sel_i)
      ple_pkg::SEL_LEFT:  value_d = left_i;
      ple_pkg::SEL_RIGHT: value_d = right_i;
      ple_pkg::SEL_HEAD:  value_d = head_i;
      ple_pkg::SEL_NEW:   value_d = new_i;
      default:            value_d = value_q;
    endcase
  end

  // slot storage, contents undefined until written
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ===== design/ple_obuf.sv =====
// ple_obuf: two-entry output buffer of result items (output register plus skid)
// lets the engine finish an item while the consumer stalls
// depends on ple_pkg
module ple_obuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ple_pkg::res_t res_i,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output ple_pkg::res_t res_o,
  output logic          full_o
);

  logic          out_v_q, out_v_d;
  logic          skid_v_q, skid_v_d;
  ple_pkg::res_t out_q, out_d;
  ple_pkg::res_t skid_q, skid_d;
  logic          pop;

  assign pop = out_v_q && !out_stall_i;

  // refill the output register from the skid first, keep order
  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (pop || !out_v_q) begin
      if (skid_v_q) begin
        out_v_d = 1'b1;
        out_d   = skid_q;
        skid_v_d = push_i;
        skid_d   = res_i;
      end else begin
        out_v_d = push_i;
        out_d   = res_i;
      end
    end else if (push_i) begin
      skid_v_d = 1'b1;
      skid_d   = res_i;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_v_q;
  assign res_o       = out_q;
  assign full_o      = skid_v_q;

endmodule

// ===== design/positional_list_engine.sv =====
// positional_list_engine: ordered list of color codes kept in a row of cells
// uses ple_pkg, ple_cell (one per list slot) and ple_obuf (result buffer)
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------------
//   in      | input     | in_valid_i/in_stall_o | operation_i, color_i, position_i
//   out     | output    | out_valid_o/out_stall_i | status_o, found_position_o,
//           |           |                       | entry_color_o, entry_count_o, last_o
//
// append, insert and delete shift the whole cell row at once.
// search, dump and reverse stay busy and stall the input until their last step: the row
// rotates a prefix through the head cell, one slot per cycle unless the buffer is full.
// dump pushes one result item per cycle and pauses while the result buffer is full.
// reset clears the count and control state; slot contents need no clearing.
// stalls on the output hold results in a two-entry buffer; input stalls while busy
// or while that buffer is full.
module positional_list_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ple_pkg::OP_W-1:0]    operation_i,
  input  logic [ple_pkg::COLOR_W-1:0] color_i,
  input  logic [ple_pkg::POS_W-1:0]   position_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic [ple_pkg::FPOS_W-1:0]  found_position_o,
  output logic [ple_pkg::COLOR_W-1:0] entry_color_o,
  output logic [ple_pkg::ECNT_W-1:0]  entry_count_o,
  output logic                        last_o
);

  localparam int CAP   = ple_pkg::CAPACITY;
  localparam int IDX_W = ple_pkg::IDX_W;
  localparam int CNT_W = ple_pkg::CNT_W;

  ple_pkg::fsm_e               state_q, state_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [IDX_W-1:0]            k_q, k_d;
  logic [IDX_W-1:0]            idx_q, idx_d;
  logic                        found_q, found_d;
  ple_pkg::op_e                op_q, op_d;
  logic [ple_pkg::COLOR_W-1:0] color_q, color_d;

  logic [ple_pkg::COLOR_W-1:0] cell_val [CAP];
  ple_pkg::sel_e               cell_sel [CAP];
  logic [ple_pkg::COLOR_W-1:0] head;

  ple_pkg::op_e     op_in;
  ple_pkg::res_t    res;
  ple_pkg::res_t    res_out;
  logic             push;
  logic             buf_full;
  logic             accept;
  logic             start;
  logic             step;
  logic             final_step;
  logic             ins_en, del_en, rot_en;
  logic [CNT_W-1:0] ipos;
  logic [CNT_W-1:0] dpos;
  logic [IDX_W-1:0] tgt;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] last_idx;
  logic             hit;

  assign op_in    = ple_pkg::op_e'(operation_i);
  assign head     = cell_val[0];
  assign cnt_m1   = count_q - CNT_W'(1);
  assign last_idx = cnt_m1[IDX_W-1:0];
  assign dpos     = CNT_W'(position_i);

  // handshake
  assign in_stall_o = (state_q != ple_pkg::FSM_IDLE) || buf_full;
  assign accept     = in_valid_i && !in_stall_o;

  // multi-cycle commands enter the busy state
  assign start = accept &&
                 ((((op_in == ple_pkg::OP_SEARCH) || (op_in == ple_pkg::OP_DUMP)) &&
                   (count_q != '0)) ||
                  ((op_in == ple_pkg::OP_REVERSE) && (count_q > CNT_W'(1))));

  // one rotation step per cycle while there is room for a result
  assign step       = (state_q == ple_pkg::FSM_BUSY) && !buf_full;
  assign final_step = (op_q == ple_pkg::OP_REVERSE) ? (k_q == last_idx - IDX_W'(1))
                                                    : (k_q == last_idx);
  assign hit        = (head == color_q) && !found_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ple_pkg::FSM_IDLE: begin
        if (start) state_d = ple_pkg::FSM_BUSY;
      end
      ple_pkg::FSM_BUSY: begin
        if (step && final_step) state_d = ple_pkg::FSM_IDLE;
      end
      default: state_d = ple_pkg::FSM_IDLE;
    endcase
  end

  // command decode, result building and scan bookkeeping
  always_comb begin
    count_d = count_q;
    k_d     = k_q;
    idx_d   = idx_q;
    found_d = found_q;
    op_d    = op_q;
    color_d = color_q;
    ins_en  = 1'b0;
    del_en  = 1'b0;
    rot_en  = 1'b0;
    tgt     = last_idx;
    ipos    = count_q;
    push    = 1'b0;
    res     = '0;
    case (state_q)
      ple_pkg::FSM_IDLE: begin
        if (accept) begin
          op_d    = op_in;
          color_d = color_i;
          k_d     = '0;
          idx_d   = '0;
          found_d = 1'b0;
          case (op_in)
            ple_pkg::OP_APPEND, ple_pkg::OP_INSERT: begin
              ipos = (op_in == ple_pkg::OP_APPEND) ? count_q : dpos;
              push = 1'b1;
              if (color_i == ple_pkg::COLOR_INVALID) begin
                res.status = ple_pkg::ST_BAD_COLOR;
              end else if (ipos > count_q) begin
                res.status = ple_pkg::ST_BAD_POS;
              end else if (count_q >= CNT_W'(CAP)) begin
                res.status = ple_pkg::ST_FULL;
              end else begin
                res.status = ple_pkg::ST_OK;
                ins_en     = 1'b1;
                count_d    = count_q + CNT_W'(1);
              end
              res.entry_count = ple_pkg::ECNT_W'(count_d);
              res.last        = 1'b1;
            end
            ple_pkg::OP_DELETE: begin
              push = 1'b1;
              if (dpos >= count_q) begin
                res.status = ple_pkg::ST_BAD_POS;
              end else begin
                res.status = ple_pkg::ST_OK;
                del_en     = 1'b1;
                count_d    = cnt_m1;
              end
              res.entry_count = ple_pkg::ECNT_W'(count_d);
              res.last        = 1'b1;
            end
            ple_pkg::OP_SEARCH: begin
              if (count_q == '0) begin
                push            = 1'b1;
                res.status      = ple_pkg::ST_NOT_FOUND;
                res.entry_count = ple_pkg::ECNT_W'(count_q);
                res.last        = 1'b1;
              end
            end
            ple_pkg::OP_REVERSE: begin
              if (count_q <= CNT_W'(1)) begin
                push            = 1'b1;
                res.status      = ple_pkg::ST_OK;
                res.entry_count = ple_pkg::ECNT_W'(count_q);
                res.last        = 1'b1;
              end
            end
            ple_pkg::OP_DUMP: begin
              if (count_q == '0) begin
                push            = 1'b1;
                res.status      = ple_pkg::ST_EMPTY;
                res.entry_count = ple_pkg::ECNT_W'(count_q);
                res.last        = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ple_pkg::FSM_BUSY: begin
        if (step) begin
          rot_en          = 1'b1;
          k_d             = k_q + IDX_W'(1);
          res.entry_count = ple_pkg::ECNT_W'(count_q);
          case (op_q)
            ple_pkg::OP_SEARCH: begin
              if (hit) begin
                found_d = 1'b1;
                idx_d   = k_q;
              end
              if (final_step) begin
                push     = 1'b1;
                res.last = 1'b1;
                if (found_q || hit) begin
                  res.status         = ple_pkg::ST_OK;
                  res.found_position = ple_pkg::FPOS_W'(hit ? k_q : idx_q);
                end else begin
                  res.status = ple_pkg::ST_NOT_FOUND;
                end
              end
            end
            ple_pkg::OP_REVERSE: begin
              // move the head behind the part already reversed
              tgt = last_idx - k_q;
              if (final_step) begin
                push       = 1'b1;
                res.status = ple_pkg::ST_OK;
                res.last   = 1'b1;
              end
            end
            default: begin
              // dump: one entry leaves the head each cycle while the result buffer has room
              push               = 1'b1;
              res.status         = ple_pkg::ST_OK;
              res.found_position = ple_pkg::FPOS_W'(k_q);
              res.entry_color    = head;
              res.last           = final_step;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // per-cell select from its place relative to the command position
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      cell_sel[i] = ple_pkg::SEL_HOLD;
      if (ins_en) begin
        if (CNT_W'(i) > ipos) cell_sel[i] = ple_pkg::SEL_LEFT;
        else if (CNT_W'(i) == ipos) cell_sel[i] = ple_pkg::SEL_NEW;
      end else if (del_en) begin
        if (CNT_W'(i) >= dpos) cell_sel[i] = ple_pkg::SEL_RIGHT;
      end else if (rot_en) begin
        if (IDX_W'(i) < tgt) cell_sel[i] = ple_pkg::SEL_RIGHT;
        else if (IDX_W'(i) == tgt) cell_sel[i] = ple_pkg::SEL_HEAD;
      end
    end
  end

  // row of cells, ends fed back from themselves
  for (genvar g = 0; g < CAP; g++) begin : g_cell
    ple_cell u_cell (
      .clk_i   (clk_i),
      .sel_i   (cell_sel[g]),
      .left_i  (cell_val[(g == 0) ? 0 : g - 1]),
      .right_i (cell_val[(g == CAP - 1) ? CAP - 1 : g + 1]),
      .head_i  (head),
      .new_i   (color_i),
      .value_o (cell_val[g])
    );
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ple_pkg::FSM_IDLE;
      count_q <= '0;
      k_q     <= '0;
      found_q <= 1'b0;
      idx_q   <= '0;
      op_q    <= ple_pkg::OP_APPEND;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      k_q     <= k_d;
      found_q <= found_d;
      idx_q   <= idx_d;
      op_q    <= op_d;
    end
  end

  // latched search color
  always_ff @(posedge clk_i) begin
    color_q <= color_d;
  end

  // result buffer
  ple_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_out),
    .full_o      (buf_full)
  );

  assign status_o         = res_out.status;
  assign found_position_o = res_out.found_position;
  assign entry_color_o    = res_out.entry_color;
  assign entry_count_o    = res_out.entry_count;
  assign last_o           = res_out.last;

  // checks
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !buf_full)
    else $error("result pushed into a full buffer");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAP))
    else $error("entry count above capacity");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_en |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the list by one");

  a_scan_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && final_step) |=> (state_q == ple_pkg::FSM_IDLE))
    else $error("scan did not end after its last step");

endmodule
